FILE: rtl/clas_pkg.sv
// ----------------------------------------------------------------------------
// clas_pkg
// shared types and constants of the command-line argument splitter
// ----------------------------------------------------------------------------
package clas_pkg;

    // field widths fixed by the interface
    localparam int CH_W    = 16;
    localparam int BS_W    = 8;
    localparam int ARG_W   = 15;
    localparam int UNIT_W  = 16;
    localparam int PHASE_W = 3;

    // characters
    localparam logic [CH_W-1:0] CH_NUL   = 16'h0000;
    localparam logic [CH_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CH_W-1:0] CH_QUOTE = 16'h0022;
    localparam logic [CH_W-1:0] CH_BSL   = 16'h005C;

    // argument counter stops here so that the total fits in ARG_W bits
    localparam logic [ARG_W-1:0] ARG_LIMIT = 15'd32766;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_NAME   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_NAME_Q = 3'd2;
    localparam logic [PHASE_W-1:0] PH_GAP    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ARG    = 3'd4;

    // control part of the parse state
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               in_quote;
        logic               quote_pending;
        logic               run_overflow;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{
        phase:         PH_START,
        in_quote:      1'b0,
        quote_pending: 1'b0,
        run_overflow:  1'b0
    };

    // one result
    typedef struct packed {
        logic [BS_W-1:0]   backslashes;
        logic              has_char;
        logic [CH_W-1:0]   char_out;
        logic              arg_end;
        logic [ARG_W-1:0]  arg_index;
        logic              line_end;
        logic [ARG_W-1:0]  arg_total;
        logic [UNIT_W-1:0] unit_total;
        logic              run_saturated;
    } res_t;

endpackage

FILE: rtl/clas_step.sv
// ----------------------------------------------------------------------------
// clas_step
// one character of the splitter: next parse state and the optional result
// ----------------------------------------------------------------------------
module clas_step #(
    parameter int CHAR_BITS = 16,
    parameter int RUN_MAX   = 255,
    parameter int MAX_LINE  = 32767,
    localparam int RUN_W    = $clog2(RUN_MAX + 1)
) (
    input  logic [clas_pkg::CH_W-1:0]   ch,
    input  clas_pkg::ctl_t              ctl,
    input  logic [RUN_W-1:0]            run_count,
    input  logic [clas_pkg::ARG_W-1:0]  arg_number,
    input  logic [clas_pkg::UNIT_W-1:0] unit_count,
    output clas_pkg::ctl_t              ctl_next,
    output logic [RUN_W-1:0]            run_next,
    output logic [clas_pkg::ARG_W-1:0]  arg_next,
    output logic [clas_pkg::UNIT_W-1:0] unit_next,
    output logic                        emit,
    output clas_pkg::res_t              res
);

    localparam logic [clas_pkg::CH_W-1:0] CharMask =
        clas_pkg::CH_W'((32'd1 << CHAR_BITS) - 32'd1);
    localparam int SUM_W = clas_pkg::UNIT_W + 2;

    logic [clas_pkg::CH_W-1:0]   c;
    logic                        is_blank;
    logic                        is_nul;
    logic                        is_quote;
    logic                        is_bsl;
    clas_pkg::ctl_t              ctl_upd;
    logic [RUN_W-1:0]            run_upd;
    logic [clas_pkg::ARG_W-1:0]  arg_upd;
    logic                        name_go;
    logic                        quoted;
    logic                        arg_go;
    logic                        iq;
    logic                        qp;
    logic [RUN_W-1:0]            r;
    logic [RUN_W-1:0]            half;
    logic [RUN_W:0]              unit_add;
    logic [RUN_W-1:0]            bs;
    logic                        hc;
    logic [clas_pkg::CH_W-1:0]   co;
    logic                        aend;
    logic                        lend;
    logic                        clear;
    logic [SUM_W-1:0]            unit_sum;
    logic [clas_pkg::UNIT_W-1:0] unit_new;

    always_comb
    begin
        c        = ch & CharMask;
        is_blank = (c == clas_pkg::CH_SPACE) || (c == clas_pkg::CH_TAB);
        is_nul   = (c == clas_pkg::CH_NUL);
        is_quote = (c == clas_pkg::CH_QUOTE);
        is_bsl   = (c == clas_pkg::CH_BSL);

        ctl_upd  = ctl;
        run_upd  = run_count;
        arg_upd  = arg_number;
        name_go  = 1'b0;
        quoted   = 1'b0;
        arg_go   = 1'b0;
        iq       = ctl.in_quote;
        qp       = ctl.quote_pending;
        r        = run_count;
        half     = run_count >> 1;
        unit_add = '0;
        emit     = 1'b0;
        bs       = '0;
        hc       = 1'b0;
        co       = c;
        aend     = 1'b0;
        lend     = 1'b0;
        clear    = 1'b0;

        case (ctl.phase)
            clas_pkg::PH_NAME, clas_pkg::PH_NAME_Q:
            begin
                name_go = 1'b1;
                quoted  = (ctl.phase == clas_pkg::PH_NAME_Q);
            end
            clas_pkg::PH_GAP:
            begin
                if (is_nul)
                begin
                    emit  = 1'b1;
                    lend  = 1'b1;
                    clear = 1'b1;
                end
                else if (!is_blank)
                begin
                    // first character of a new argument
                    if (arg_number < clas_pkg::ARG_LIMIT)
                    begin
                        arg_upd = arg_number + 1'b1;
                    end
                    ctl_upd.phase = clas_pkg::PH_ARG;
                    arg_go = 1'b1;
                    iq     = 1'b0;
                    qp     = 1'b0;
                    r      = '0;
                    half   = '0;
                end
            end
            clas_pkg::PH_ARG:
            begin
                arg_go = 1'b1;
            end
            default:
            begin
                // program name start
                if (is_quote)
                begin
                    ctl_upd.phase = clas_pkg::PH_NAME_Q;
                end
                else
                begin
                    ctl_upd.phase = clas_pkg::PH_NAME;
                    name_go = 1'b1;
                end
            end
        endcase

        // program name: no escapes
        if (name_go)
        begin
            unit_add = (RUN_W+1)'(1);
            emit     = 1'b1;
            if (is_nul)
            begin
                aend  = 1'b1;
                lend  = 1'b1;
                clear = 1'b1;
            end
            else if (quoted ? is_quote : is_blank)
            begin
                aend          = 1'b1;
                ctl_upd.phase = clas_pkg::PH_GAP;
            end
            else
            begin
                hc = 1'b1;
            end
        end

        // later arguments: backslash and quote rules
        if (arg_go)
        begin
            ctl_upd.quote_pending = 1'b0;
            if (qp)
            begin
                iq = 1'b0;
            end
            ctl_upd.in_quote = iq;
            if (qp && is_quote)
            begin
                // doubled quote inside quotes
                unit_add = (RUN_W+1)'(1);
                emit     = 1'b1;
                hc       = 1'b1;
                co       = clas_pkg::CH_QUOTE;
            end
            else if (is_bsl)
            begin
                if (r < RUN_W'(RUN_MAX))
                begin
                    run_upd = r + 1'b1;
                end
                else
                begin
                    run_upd = r;
                    ctl_upd.run_overflow = 1'b1;
                end
            end
            else
            begin
                run_upd = '0;
                if (is_quote)
                begin
                    bs = half;
                    if (r[0])
                    begin
                        // odd run escapes the quote
                        unit_add = {1'b0, half} + 1'b1;
                        emit     = 1'b1;
                        hc       = 1'b1;
                    end
                    else
                    begin
                        unit_add = {1'b0, half};
                        if (iq)
                        begin
                            ctl_upd.quote_pending = 1'b1;
                        end
                        else
                        begin
                            ctl_upd.in_quote = 1'b1;
                        end
                        emit = (half != '0);
                    end
                end
                else
                begin
                    unit_add = {1'b0, r} + 1'b1;
                    bs       = r;
                    emit     = 1'b1;
                    if (is_nul)
                    begin
                        aend  = 1'b1;
                        lend  = 1'b1;
                        clear = 1'b1;
                    end
                    else if (!iq && is_blank)
                    begin
                        aend          = 1'b1;
                        ctl_upd.phase = clas_pkg::PH_GAP;
                    end
                    else
                    begin
                        hc = 1'b1;
                    end
                end
            end
        end

        // saturating character count
        unit_sum = SUM_W'(unit_count) + SUM_W'(unit_add);
        if (unit_sum > SUM_W'(MAX_LINE))
        begin
            unit_new = clas_pkg::UNIT_W'(MAX_LINE);
        end
        else
        begin
            unit_new = unit_sum[clas_pkg::UNIT_W-1:0];
        end

        res.backslashes   = clas_pkg::BS_W'(bs);
        res.has_char      = hc;
        res.char_out      = hc ? co : '0;
        res.arg_end       = aend;
        res.arg_index     = arg_upd;
        res.line_end      = lend;
        res.arg_total     = lend ? (arg_upd + 1'b1) : '0;
        res.unit_total    = lend ? unit_new : '0;
        res.run_saturated = ctl_upd.run_overflow;

        // nul ends the line and restarts the parse
        if (clear)
        begin
            ctl_next  = clas_pkg::CTL_RESET;
            run_next  = '0;
            arg_next  = '0;
            unit_next = '0;
        end
        else
        begin
            ctl_next  = ctl_upd;
            run_next  = run_upd;
            arg_next  = arg_upd;
            unit_next = unit_new;
        end
    end

endmodule

FILE: rtl/command_line_argument_splitter.sv
// ----------------------------------------------------------------------------
// command_line_argument_splitter
// splits a command-line character stream into arguments, one char a request
// ----------------------------------------------------------------------------
// usage
//   input channel: ch with ch_valid / ch_stall, one character per request;
//   a nul character ends the line, reports the totals and restarts parsing
//   output channel: the result fields with res_valid / res_stall; a
//   character that appends nothing and ends nothing gives no result
//   (blanks between arguments, backslashes, an opening quote)
//   path: a result reaches the result register after its character is
//   taken into the input register, then through the parse logic into the
//   result register
//   throughput: one character per cycle while no stall holds it; the
//   state update is combinational between the input and result registers
//   reset: rst_n clears the valid bits of both registers and the parse
//   state; the block then expects the first character of the program name
//   stall: while res_stall holds a waiting result, the character in the
//   input register waits, ch_stall rises, and the state does not move
// ----------------------------------------------------------------------------
module command_line_argument_splitter #(
    parameter int CHAR_BITS = 16,
    parameter int RUN_MAX   = 255,
    parameter int MAX_LINE  = 32767
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // character requests
    input  logic                        ch_valid,
    output logic                        ch_stall,
    input  logic [clas_pkg::CH_W-1:0]   ch,
    // result requests
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [clas_pkg::BS_W-1:0]   backslashes,
    output logic                        has_char,
    output logic [clas_pkg::CH_W-1:0]   char_out,
    output logic                        arg_end,
    output logic [clas_pkg::ARG_W-1:0]  arg_index,
    output logic                        line_end,
    output logic [clas_pkg::ARG_W-1:0]  arg_total,
    output logic [clas_pkg::UNIT_W-1:0] unit_total,
    output logic                        run_saturated
);

    localparam int RUN_W = $clog2(RUN_MAX + 1);

    // input register
    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [clas_pkg::CH_W-1:0]   ch_reg;

    // parse state
    clas_pkg::ctl_t              ctl_reg;
    clas_pkg::ctl_t              ctl_next;
    logic [RUN_W-1:0]            run_reg;
    logic [RUN_W-1:0]            run_next;
    logic [clas_pkg::ARG_W-1:0]  arg_reg;
    logic [clas_pkg::ARG_W-1:0]  arg_next;
    logic [clas_pkg::UNIT_W-1:0] unit_reg;
    logic [clas_pkg::UNIT_W-1:0] unit_next;

    // result register
    logic                        res_valid_reg;
    logic                        res_valid_next;
    clas_pkg::res_t              res_reg;
    clas_pkg::res_t              step_res;
    logic                        step_emit;

    logic                        ch_take;
    logic                        res_free;
    logic                        advance;

    // result register free when empty or being taken this cycle
    assign res_free = !res_valid_reg || !res_stall;
    assign advance  = in_valid_reg && res_free;
    assign ch_stall = in_valid_reg && !res_free;
    assign ch_take  = ch_valid && !ch_stall;

    clas_step #(
        .CHAR_BITS (CHAR_BITS),
        .RUN_MAX   (RUN_MAX),
        .MAX_LINE  (MAX_LINE)
    ) u_step (
        .ch         (ch_reg),
        .ctl        (ctl_reg),
        .run_count  (run_reg),
        .arg_number (arg_reg),
        .unit_count (unit_reg),
        .ctl_next   (ctl_next),
        .run_next   (run_next),
        .arg_next   (arg_next),
        .unit_next  (unit_next),
        .emit       (step_emit),
        .res        (step_res)
    );

    always_comb
    begin
        if (ch_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance && step_emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            ctl_reg       <= clas_pkg::CTL_RESET;
            run_reg       <= '0;
            arg_reg       <= '0;
            unit_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                ctl_reg  <= ctl_next;
                run_reg  <= run_next;
                arg_reg  <= arg_next;
                unit_reg <= unit_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ch_take)
        begin
            ch_reg <= ch;
        end
        if (advance && step_emit)
        begin
            res_reg <= step_res;
        end
    end

    assign res_valid     = res_valid_reg;
    assign backslashes   = res_reg.backslashes;
    assign has_char      = res_reg.has_char;
    assign char_out      = res_reg.char_out;
    assign arg_end       = res_reg.arg_end;
    assign arg_index     = res_reg.arg_index;
    assign line_end      = res_reg.line_end;
    assign arg_total     = res_reg.arg_total;
    assign unit_total    = res_reg.unit_total;
    assign run_saturated = res_reg.run_saturated;

endmodule
